/* design/ulsr_pkg.sv */
// ----------------------------------------------------------------------------
// ulsr_pkg
// Types, widths and constants of the underfrequency load shedding relay.
// ----------------------------------------------------------------------------
`default_nettype none

package ulsr_pkg;

	localparam int LOAD_W        = 8;
	localparam int FREQ_W        = 24;
	localparam int ROC_W         = 20;
	localparam int HOLD_W        = 16;
	localparam int COUNT_W       = 16;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_ADDR_W    = 4;

	localparam int LOAD_COUNT    = 8;
	localparam int SAMPLE_RATE   = 16000;
	localparam int FRACTION_BITS = 10;

	// shared divider: numerator holds 2*f*p, denominator holds f+p
	localparam int DIV_NUM_W = 2 * FREQ_W + 1;
	localparam int DIV_DEN_W = FREQ_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
	localparam int H_W       = FREQ_W + 1;

	localparam logic [DIV_NUM_W-1:0] F_NUMER =
		DIV_NUM_W'(SAMPLE_RATE) << FRACTION_BITS;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
	localparam logic [ROC_W-1:0]  ROC_MAX  = {ROC_W{1'b1}};

	localparam logic [FREQ_W-1:0] FREQ_FLOOR_RST = FREQ_W'(51200);
	localparam logic [ROC_W-1:0]  MAX_ROC_RST    = ROC_W'(10240);
	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(500);

	typedef enum logic [1:0] {
		CMD_FREQ   = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_BUTTON = 2'd2,
		CMD_SWITCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_MANAGE = 2'd1,
		MODE_MAINT  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_FREQ_FLOOR = 2'd0,
		REG_MAX_ROC    = 2'd1,
		REG_HOLD_TICKS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DIV_F,
		SQ_MUL_FP,
		SQ_START_H,
		SQ_DIV_H,
		SQ_MUL_ROC,
		SQ_APPLY,
		SQ_OUT
	} seq_state_t;

	// one finished sample or command handed to the relay control
	typedef struct packed {
		logic              apply;
		cmd_t              cmd;
		logic [LOAD_W-1:0] sw;
		logic [FREQ_W-1:0] freq;
		logic [ROC_W-1:0]  roc;
	} relay_evt_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_floor;
		logic [ROC_W-1:0]  max_roc;
		logic [HOLD_W-1:0] hold_ticks;
	} relay_cfg_t;

endpackage

`default_nettype wire

/* design/ulsr_in_if.sv */
// ----------------------------------------------------------------------------
// ulsr_in_if
// Input item channel: valid/ready handshake with command and sample payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulsr_in_if;
	import ulsr_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [COUNT_W-1:0] period_count;
	logic [LOAD_W-1:0]  switches;

	modport source (output valid, command, period_count, switches, input ready);
	modport sink   (input valid, command, period_count, switches, output ready);
endinterface

`default_nettype wire

/* design/ulsr_out_if.sv */
// ----------------------------------------------------------------------------
// ulsr_out_if
// Result item channel: valid/ready handshake with relay status payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ulsr_out_if;
	import ulsr_pkg::*;

	logic              valid;
	logic              ready;
	logic [LOAD_W-1:0] loads_on;
	logic [LOAD_W-1:0] loads_shed;
	logic              stable;
	logic [1:0]        mode;
	logic [FREQ_W-1:0] frequency;
	logic [ROC_W-1:0]  roc;

	modport source (output valid, loads_on, loads_shed, stable, mode, frequency, roc,
		input ready);
	modport sink   (input valid, loads_on, loads_shed, stable, mode, frequency, roc,
		output ready);
endinterface

`default_nettype wire

/* design/ulsr_div.sv */
// ----------------------------------------------------------------------------
// ulsr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ulsr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ulsr_pkg::DIV_NUM_W-1:0] num,
	input  wire logic [ulsr_pkg::DIV_DEN_W-1:0] den,
	output logic                               done,
	output logic [ulsr_pkg::DIV_NUM_W-1:0]      quo
);
	import ulsr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < den_q)
		else $error("divider remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider running with empty step count");
endmodule

`default_nettype wire

/* design/ulsr_ctrl.sv */
// ----------------------------------------------------------------------------
// ulsr_ctrl
// Relay control: mode, live and held loads, stability and hold timer.
// ----------------------------------------------------------------------------
`default_nettype none

module ulsr_ctrl #(
	parameter int LOAD_COUNT = ulsr_pkg::LOAD_COUNT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ulsr_pkg::relay_evt_t  evt,
	input  wire ulsr_pkg::relay_cfg_t  cfg,
	output logic [LOAD_COUNT-1:0]      live,
	output logic [LOAD_COUNT-1:0]      held,
	output logic                       stable,
	output ulsr_pkg::mode_t            mode
);
	import ulsr_pkg::*;

	mode_t                 mode_q, mode_d;
	logic [LOAD_COUNT-1:0] live_q, live_d;
	logic [LOAD_COUNT-1:0] held_q, held_d;
	logic [LOAD_COUNT-1:0] latch_q, latch_d;
	logic                  stable_q, stable_d;
	logic                  last_stable_q, last_stable_d;
	logic                  hold_run_q, hold_run_d;
	logic [HOLD_W-1:0]     hold_cnt_q, hold_cnt_d;

	logic [LOAD_COUNT-1:0] shed_bit;
	logic [LOAD_COUNT-1:0] rest_cand;
	logic [LOAD_COUNT-1:0] rest_bit;
	logic [LOAD_COUNT-1:0] sw_ext;
	logic [HOLD_W-1:0]     limit;
	logic [HOLD_W:0]       cnt_inc;
	logic                  stable_new;

	assign shed_bit   = live_q & (~live_q + 1'b1);
	assign rest_cand  = held_q & latch_q;
	assign sw_ext     = LOAD_COUNT'(evt.sw);
	assign limit      = (cfg.hold_ticks == '0) ? HOLD_W'(1) : cfg.hold_ticks;
	assign cnt_inc    = {1'b0, hold_cnt_q} + 1'b1;
	assign stable_new = !(evt.freq < cfg.freq_floor || evt.roc >= cfg.max_roc);

	// highest held load whose switch is on
	always_comb begin
		rest_bit = '0;
		for (int b = 0; b < LOAD_COUNT; b++) begin
			if (rest_cand[b]) begin
				rest_bit = '0;
				rest_bit[b] = 1'b1;
			end
		end
	end

	always_comb begin
		mode_d        = mode_q;
		live_d        = live_q;
		held_d        = held_q;
		latch_d       = latch_q;
		stable_d      = stable_q;
		last_stable_d = last_stable_q;
		hold_run_d    = hold_run_q;
		hold_cnt_d    = hold_cnt_q;
		if (evt.apply) begin
			case (evt.cmd)
				CMD_FREQ: begin
					stable_d = stable_new;
					if (!stable_new && mode_q == MODE_NORMAL) begin
						mode_d        = MODE_MANAGE;
						live_d        = live_q & ~shed_bit;
						held_d        = held_q | shed_bit;
						last_stable_d = 1'b0;
						hold_run_d    = 1'b1;
						hold_cnt_d    = '0;
					end else if (mode_q == MODE_MANAGE) begin
						if (stable_new != last_stable_q) hold_cnt_d = '0;
						last_stable_d = stable_new;
					end
				end
				CMD_TICK: begin
					if (mode_q == MODE_MANAGE && hold_run_q) begin
						if (cnt_inc >= {1'b0, limit}) begin
							hold_cnt_d = '0;
							if (stable_q) begin
								// release held loads from the top down to the restored one
								held_d = (rest_bit != '0) ? (held_q & (rest_bit - 1'b1)) : '0;
								live_d = live_q | rest_bit;
								if (held_d == '0) begin
									mode_d     = MODE_NORMAL;
									hold_run_d = 1'b0;
								end
							end else begin
								live_d = live_q & ~shed_bit;
								held_d = held_q | shed_bit;
							end
						end else begin
							hold_cnt_d = HOLD_W'(cnt_inc);
						end
					end
				end
				CMD_BUTTON: begin
					if (mode_q == MODE_NORMAL) mode_d = MODE_MAINT;
					else if (mode_q == MODE_MAINT) mode_d = MODE_NORMAL;
					if (mode_d != MODE_MANAGE) begin
						hold_run_d = 1'b0;
						hold_cnt_d = '0;
					end
				end
				CMD_SWITCH: begin
					latch_d = sw_ext;
					if (mode_q == MODE_MANAGE) live_d = live_q & sw_ext;
					else live_d = sw_ext;
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NORMAL;
			live_q        <= '1;
			held_q        <= '0;
			latch_q       <= '1;
			stable_q      <= 1'b1;
			last_stable_q <= 1'b1;
			hold_run_q    <= 1'b0;
			hold_cnt_q    <= '0;
		end else begin
			mode_q        <= mode_d;
			live_q        <= live_d;
			held_q        <= held_d;
			latch_q       <= latch_d;
			stable_q      <= stable_d;
			last_stable_q <= last_stable_d;
			hold_run_q    <= hold_run_d;
			hold_cnt_q    <= hold_cnt_d;
		end
	end

	assign live   = live_q;
	assign held   = held_q;
	assign stable = stable_q;
	assign mode   = mode_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q & held_q) == '0)
		else $error("load both live and held");
	a_held_only_managing: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_MANAGE |-> held_q == '0)
		else $error("loads held outside load managing");
	a_hold_only_managing: assert property (@(posedge clk) disable iff (!arst_n)
		hold_run_q |-> mode_q == MODE_MANAGE)
		else $error("hold timer running outside load managing");
endmodule

`default_nettype wire

/* design/underfrequency_load_shed_relay.sv */
// ----------------------------------------------------------------------------
// underfrequency_load_shed_relay
// Period count to frequency, rate of change and load shed/restore control.
// ----------------------------------------------------------------------------
// Frequency sample: two 49-step passes of the shared restoring divider
// (frequency, then the harmonic mean used for the rate of change) plus the
// sequencing states; a count of zero or a zero sum skips a division.
// Tick, button and switch items pass only the APPLY and OUT states. The next
// item is taken only after the result is loaded into the output register.
// Reset (arst_n low, asynchronous) returns control state and config.
`default_nettype none

module underfrequency_load_shed_relay #(
	parameter int LOAD_COUNT = ulsr_pkg::LOAD_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ulsr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [ulsr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ulsr_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	ulsr_in_if.sink                             items_in,
	ulsr_out_if.source                          results_out
);
	import ulsr_pkg::*;

	seq_state_t state_q, state_d;

	relay_cfg_t cfg_q;
	relay_evt_t evt;
	reg_idx_t   reg_idx;

	cmd_t                 cmd_q;
	logic [LOAD_W-1:0]    sw_q;
	logic [FREQ_W-1:0]    f_q;
	logic [FREQ_W-1:0]    prev_freq_q;
	logic [ROC_W-1:0]     roc_q;
	logic [H_W-1:0]       h_q;
	logic [DIV_NUM_W-1:0] prod_q;

	logic                 in_fire;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [DIV_DEN_W-1:0] fp_sum;
	logic [FREQ_W-1:0]    fp_diff;
	logic [FREQ_W-1:0]    mul_a;
	logic [H_W-1:0]       mul_b;
	logic [DIV_NUM_W-1:0] mul_p;
	logic [DIV_NUM_W-1:0] roc_full;
	logic [ROC_W-1:0]     roc_sat;
	logic                 out_load;

	logic [LOAD_COUNT-1:0] live;
	logic [LOAD_COUNT-1:0] held;
	logic                  stable;
	mode_t                 mode;

	logic              out_valid_q;
	logic [LOAD_W-1:0] out_on_q;
	logic [LOAD_W-1:0] out_shed_q;
	logic              out_stable_q;
	logic [1:0]        out_mode_q;
	logic [FREQ_W-1:0] out_freq_q;
	logic [ROC_W-1:0]  out_roc_q;

	// configuration port
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_floor <= FREQ_FLOOR_RST;
			cfg_q.max_roc    <= MAX_ROC_RST;
			cfg_q.hold_ticks <= HOLD_TICKS_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_FREQ_FLOOR: cfg_q.freq_floor <= pwdata[FREQ_W-1:0];
				REG_MAX_ROC:    cfg_q.max_roc    <= pwdata[ROC_W-1:0];
				REG_HOLD_TICKS: cfg_q.hold_ticks <= pwdata[HOLD_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FREQ_FLOOR: prdata = CFG_DATA_W'(cfg_q.freq_floor);
			REG_MAX_ROC:    prdata = CFG_DATA_W'(cfg_q.max_roc);
			REG_HOLD_TICKS: prdata = CFG_DATA_W'(cfg_q.hold_ticks);
			default:        prdata = '0;
		endcase
	end

	// sequencer
	assign items_in.ready = (state_q == SQ_IDLE);
	assign in_fire        = items_in.valid && items_in.ready;
	assign out_load       = (state_q == SQ_OUT) && (!out_valid_q || results_out.ready);

	assign fp_sum  = {1'b0, f_q} + {1'b0, prev_freq_q};
	assign fp_diff = (f_q >= prev_freq_q) ? (f_q - prev_freq_q) : (prev_freq_q - f_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (in_fire) begin
					if (cmd_t'(items_in.command) == CMD_FREQ)
						state_d = (items_in.period_count != '0) ? SQ_DIV_F : SQ_MUL_FP;
					else
						state_d = SQ_APPLY;
				end
			end
			SQ_DIV_F:   if (div_done) state_d = SQ_MUL_FP;
			SQ_MUL_FP:  state_d = SQ_START_H;
			SQ_START_H: state_d = (fp_sum == '0) ? SQ_MUL_ROC : SQ_DIV_H;
			SQ_DIV_H:   if (div_done) state_d = SQ_MUL_ROC;
			SQ_MUL_ROC: state_d = SQ_APPLY;
			SQ_APPLY:   state_d = SQ_OUT;
			SQ_OUT:     if (out_load) state_d = SQ_IDLE;
			default:    state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = F_NUMER;
		div_den   = DIV_DEN_W'(items_in.period_count);
		mul_a     = f_q;
		mul_b     = {prev_freq_q, 1'b0};
		case (state_q)
			SQ_IDLE: begin
				div_start = in_fire && cmd_t'(items_in.command) == CMD_FREQ
					&& items_in.period_count != '0;
			end
			SQ_START_H: begin
				div_start = (fp_sum != '0);
				div_num   = prod_q;
				div_den   = fp_sum;
			end
			SQ_MUL_ROC: begin
				mul_a = fp_diff;
				mul_b = h_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ulsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// one multiplier: 2*f*p first, then |f-p|*h
	assign mul_p    = DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b);
	assign roc_full = prod_q >> FRACTION_BITS;
	assign roc_sat  = (roc_full > DIV_NUM_W'(ROC_MAX)) ? ROC_MAX : roc_full[ROC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			prev_freq_q <= '0;
			roc_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_APPLY && cmd_q == CMD_FREQ) begin
				prev_freq_q <= f_q;
				roc_q       <= roc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd_t'(items_in.command);
			sw_q  <= items_in.switches;
			f_q   <= '0;
		end
		if (state_q == SQ_DIV_F && div_done)
			f_q <= (div_quo > DIV_NUM_W'(FREQ_MAX)) ? FREQ_MAX : div_quo[FREQ_W-1:0];
		if (state_q == SQ_MUL_FP || state_q == SQ_MUL_ROC)
			prod_q <= mul_p;
		if (state_q == SQ_START_H && fp_sum == '0)
			h_q <= '0;
		if (state_q == SQ_DIV_H && div_done)
			h_q <= div_quo[H_W-1:0];
	end

	assign evt.apply = (state_q == SQ_APPLY);
	assign evt.cmd   = cmd_q;
	assign evt.sw    = sw_q;
	assign evt.freq  = f_q;
	assign evt.roc   = roc_sat;

	ulsr_ctrl #(
		.LOAD_COUNT (LOAD_COUNT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.cfg    (cfg_q),
		.live   (live),
		.held   (held),
		.stable (stable),
		.mode   (mode)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_on_q     <= LOAD_W'(live);
			out_shed_q   <= LOAD_W'(held);
			out_stable_q <= stable;
			out_mode_q   <= mode;
			out_freq_q   <= prev_freq_q;
			out_roc_q    <= roc_q;
		end
	end

	assign results_out.valid      = out_valid_q;
	assign results_out.loads_on   = out_on_q;
	assign results_out.loads_shed = out_shed_q;
	assign results_out.stable     = out_stable_q;
	assign results_out.mode       = out_mode_q;
	assign results_out.frequency  = out_freq_q;
	assign results_out.roc        = out_roc_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != SQ_IDLE |-> !items_in.ready)
		else $error("item taken while sequencer busy");
	a_div_waits_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_DIV_F && !div_done |=> state_q == SQ_DIV_F)
		else $error("frequency division left early");
	a_apply_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_APPLY |=> state_q == SQ_OUT)
		else $error("result not presented after update");
endmodule

`default_nettype wire

/* verif/ulsr_relay_checker.sv */
// ----------------------------------------------------------------------------
// ulsr_relay_checker
// Watches the item channels of the relay, predicts each status item from the
// commands it has seen and compares the status items field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module ulsr_relay_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ulsr_in_if.sink                items_in,
	ulsr_out_if.sink               results_out,
	input  wire logic              cfg_we,
	input  wire ulsr_pkg::reg_idx_t cfg_idx,
	input  wire logic [31:0]       cfg_val,
	output int                     fail_count,
	output int                     pending
);
	import ulsr_pkg::*;

	typedef struct packed {
		logic [LOAD_W-1:0] loads_on;
		logic [LOAD_W-1:0] loads_shed;
		logic              stable;
		logic [1:0]        mode;
		logic [FREQ_W-1:0] frequency;
		logic [ROC_W-1:0]  roc;
	} status_t;

	status_t status_q[$];

	logic [FREQ_W-1:0] freq_floor;
	logic [ROC_W-1:0]  max_roc;
	logic [HOLD_W-1:0] hold_ticks;
	mode_t             mode;
	logic [LOAD_W-1:0] live, held, sw_latch;
	logic              stable_f, last_stable, hold_on;
	logic [FREQ_W-1:0] prev_f;
	logic [ROC_W-1:0]  last_roc;
	logic [HOLD_W-1:0] hold_cnt;

	assign pending = status_q.size();

	task automatic shed_lowest();
		for (int b = 0; b < LOAD_W; b++)
			if (live[b]) begin
				live[b] = 1'b0;
				held[b] = 1'b1;
				return;
			end
	endtask

	task automatic restore_highest();
		for (int b = LOAD_W - 1; b >= 0; b--)
			if (held[b]) begin
				held[b] = 1'b0;
				if (sw_latch[b]) begin
					live[b] = 1'b1;
					break;
				end
			end
		if (held == '0) begin
			mode = MODE_NORMAL;
			hold_on = 1'b0;
			hold_cnt = '0;
		end
	endtask

	task automatic take_freq(input logic [COUNT_W-1:0] cnt);
		logic [63:0] f, p, h, d, r;
		f = 0;
		p = prev_f;
		h = 0;
		if (cnt != 0) begin
			f = ((64'(SAMPLE_RATE)) << FRACTION_BITS) / cnt;
			if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
		end
		if (f + p != 0) h = (2 * f * p) / (f + p);
		d = (f >= p) ? f - p : p - f;
		r = (d * h) >> FRACTION_BITS;
		if (r > 64'hF_FFFF) r = 64'hF_FFFF;
		prev_f = f[FREQ_W-1:0];
		last_roc = r[ROC_W-1:0];
		stable_f = !(f < freq_floor || r >= max_roc);
		if (!stable_f && mode == MODE_NORMAL) begin
			mode = MODE_MANAGE;
			shed_lowest();
			last_stable = stable_f;
			hold_on = 1'b1;
			hold_cnt = '0;
		end else if (mode == MODE_MANAGE) begin
			if (stable_f != last_stable) hold_cnt = '0;
			last_stable = stable_f;
		end
	endtask

	task automatic step_relay(input cmd_t cmd, input logic [COUNT_W-1:0] cnt,
		input logic [LOAD_W-1:0] sw);
		logic [HOLD_W-1:0] lim;
		lim = (hold_ticks == '0) ? HOLD_W'(1) : hold_ticks;
		case (cmd)
			CMD_FREQ: take_freq(cnt);
			CMD_TICK: begin
				if (mode == MODE_MANAGE && hold_on) begin
					hold_cnt++;
					if (hold_cnt >= lim) begin
						hold_cnt = '0;
						if (stable_f) restore_highest();
						else shed_lowest();
					end
				end
			end
			CMD_BUTTON: begin
				if (mode == MODE_NORMAL) mode = MODE_MAINT;
				else if (mode == MODE_MAINT) mode = MODE_NORMAL;
				if (mode != MODE_MANAGE) begin
					hold_on = 1'b0;
					hold_cnt = '0;
				end
			end
			default: begin
				sw_latch = sw;
				if (mode == MODE_MANAGE) live &= sw;
				else live = sw;
			end
		endcase
		status_q.push_back('{live, held, stable_f, mode, prev_f, last_roc});
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			freq_floor <= FREQ_FLOOR_RST;
			max_roc <= MAX_ROC_RST;
			hold_ticks <= HOLD_TICKS_RST;
			mode = MODE_NORMAL;
			live = '1;
			held = '0;
			stable_f = 1'b1;
			last_stable = 1'b1;
			prev_f = '0;
			last_roc = '0;
			hold_on = 1'b0;
			hold_cnt = '0;
			sw_latch = '1;
			fail_count = 0;
			status_q.delete();
		end else begin
			if (cfg_we)
				case (cfg_idx)
					REG_FREQ_FLOOR: freq_floor <= cfg_val[FREQ_W-1:0];
					REG_MAX_ROC:    max_roc <= cfg_val[ROC_W-1:0];
					REG_HOLD_TICKS: hold_ticks <= cfg_val[HOLD_W-1:0];
					default: ;
				endcase
			if (items_in.valid && items_in.ready)
				step_relay(cmd_t'(items_in.command), items_in.period_count,
					items_in.switches);
			if (results_out.valid && results_out.ready) begin
				if (status_q.size() == 0) begin
					report("unexpected item", 0, 0);
				end else begin
					want = status_q.pop_front();
					if (results_out.loads_on !== want.loads_on)
						report("loads_on", 32'(results_out.loads_on), 32'(want.loads_on));
					if (results_out.loads_shed !== want.loads_shed)
						report("loads_shed", 32'(results_out.loads_shed),
							32'(want.loads_shed));
					if (results_out.stable !== want.stable)
						report("stable", 32'(results_out.stable), 32'(want.stable));
					if (results_out.mode !== want.mode)
						report("mode", 32'(results_out.mode), 32'(want.mode));
					if (results_out.frequency !== want.frequency)
						report("frequency", 32'(results_out.frequency), 32'(want.frequency));
					if (results_out.roc !== want.roc)
						report("roc", 32'(results_out.roc), 32'(want.roc));
				end
			end
		end
	end

endmodule

`default_nettype wire

/* verif/tb_underfrequency_load_shed_relay.sv */
// ----------------------------------------------------------------------------
// tb_underfrequency_load_shed_relay
// Drives directed and random relay commands and register settings with bursty
// input and a stalling result side; the checker judges every status item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_underfrequency_load_shed_relay;
	import ulsr_pkg::*;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic cfg_we;
	reg_idx_t cfg_idx;
	logic [31:0] cfg_val;
	int fail_count, pending;
	int cycles;
	int gap_left, burst_left;
	int stall_phase;
	logic [15:0] grid_count;

	ulsr_in_if  items_in();
	ulsr_out_if results_out();

	underfrequency_load_shed_relay u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.items_in(items_in.sink), .results_out(results_out.source)
	);

	ulsr_relay_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.items_in(items_in.sink), .results_out(results_out.sink),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_val(cfg_val),
		.fail_count(fail_count), .pending(pending)
	);

	// checker's copy of the registers follows the apb write strobe
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_val = pwdata;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls on a rotating pattern, with calm stretches
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase >> 6) & 3)
			0: results_out.ready <= 1'b1;
			1: results_out.ready <= ($urandom_range(0, 3) != 0);
			2: results_out.ready <= stall_phase[2];
			default: results_out.ready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("** underfrequency_load_shed_relay: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one item, with gaps between random-length bursts; valid stays up inside a burst
	task automatic send_item(input cmd_t cmd, input logic [15:0] cnt,
		input logic [7:0] sw);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
		if (gap_left > 0) begin
			items_in.valid <= 1'b0;
			while (gap_left > 0) begin
				@(posedge clk);
				gap_left--;
			end
		end
		items_in.valid <= 1'b1;
		items_in.command <= cmd;
		items_in.period_count <= cnt;
		items_in.switches <= sw;
		do @(posedge clk); while (!items_in.ready);
		burst_left--;
	endtask

	task automatic drain();
		items_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// mostly near-grid counts so shedding and restoring both happen
			if ($urandom_range(0, 9) == 0) grid_count = 16'($urandom);
			else grid_count = 16'($urandom_range(300, 360));
			send_item(CMD_FREQ, grid_count, 8'($urandom));
		end else if (pick < 85) begin
			send_item(CMD_TICK, 16'($urandom), 8'($urandom));
		end else if (pick < 90) begin
			send_item(CMD_BUTTON, 16'($urandom), 8'($urandom));
		end else begin
			send_item(CMD_SWITCH, 16'($urandom),
				($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		items_in.valid = 1'b0; items_in.command = CMD_TICK;
		items_in.period_count = '0; items_in.switches = '0;
		results_out.ready = 1'b0;
		cycles = 0; stall_phase = 0; gap_left = 0; burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero count, first sample, every command
		write_reg(REG_HOLD_TICKS, 0);
		send_item(CMD_FREQ, 16'd320, 8'h00);
		send_item(CMD_FREQ, 16'd0, 8'hFF);
		send_item(CMD_TICK, 16'h0, 8'h0);
		send_item(CMD_FREQ, 16'd1, 8'h0);
		send_item(CMD_FREQ, 16'hFFFF, 8'h0);
		send_item(CMD_SWITCH, 16'hFFFF, 8'h00);
		repeat (3) send_item(CMD_TICK, 16'h0, 8'h0);
		send_item(CMD_BUTTON, 16'h0, 8'h0);
		send_item(CMD_FREQ, 16'd320, 8'h0);
		send_item(CMD_FREQ, 16'd320, 8'h0);
		repeat (10) send_item(CMD_TICK, 16'h0, 8'h0);
		send_item(CMD_BUTTON, 16'h0, 8'h0);
		send_item(CMD_FREQ, 16'd400, 8'h0);
		send_item(CMD_BUTTON, 16'h0, 8'h0);
		send_item(CMD_SWITCH, 16'h0, 8'hA5);
		send_item(CMD_BUTTON, 16'h0, 8'h0);
		send_item(CMD_SWITCH, 16'h0, 8'hFF);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_FREQ_FLOOR, 32'(FREQ_FLOOR_RST));
					write_reg(REG_MAX_ROC, 32'(MAX_ROC_RST));
					write_reg(REG_HOLD_TICKS, 3);
				end
				1: begin
					write_reg(REG_FREQ_FLOOR, 0);
					write_reg(REG_MAX_ROC, 32'hF_FFFF);
					write_reg(REG_HOLD_TICKS, 1);
				end
				2: begin
					write_reg(REG_FREQ_FLOOR, 32'hFF_FFFF);
					write_reg(REG_MAX_ROC, 0);
					write_reg(REG_HOLD_TICKS, 32'hFFFF);
				end
				3: begin
					write_reg(REG_FREQ_FLOOR, 32'(49 * 1024));
					write_reg(REG_MAX_ROC, 32'(50 * 1024));
					write_reg(REG_HOLD_TICKS, 2);
				end
				default: begin
					write_reg(REG_FREQ_FLOOR, $urandom_range(48 * 1024, 52 * 1024));
					write_reg(REG_MAX_ROC, $urandom_range(0, 32'hF_FFFF));
					write_reg(REG_HOLD_TICKS, $urandom_range(0, 5));
				end
			endcase
			repeat (140) random_item();
			drain();
		end

		if (fail_count == 0)
			$display("** underfrequency_load_shed_relay: PASSED **");
		else
			$display("** underfrequency_load_shed_relay: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
design/ulsr_pkg.sv
design/ulsr_in_if.sv
design/ulsr_out_if.sv
design/ulsr_div.sv
design/ulsr_ctrl.sv
design/underfrequency_load_shed_relay.sv
verif/ulsr_relay_checker.sv
verif/tb_underfrequency_load_shed_relay.sv
